// ===== hdl/symmetric_fir_lowpass_edge_hold_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the symmetric FIR low-pass filter with edge hold.
// Uses clk and rst_n from the scope that expands them.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_FIR_LOWPASS_EDGE_HOLD_DEFINES_SVH
`define SYMMETRIC_FIR_LOWPASS_EDGE_HOLD_DEFINES_SVH

`ifndef ASSERT_OFF
`define SFIR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SFIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFIR_ASSERT_SAME(label, ante, cons, msg)
`define SFIR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hdl/sfir_pkg.sv =====
// ----------------------------------------------------------------------------
// sfir_pkg
// Sizes, word types and control groups shared by the filter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfir_pkg;

    localparam int HALF_TAPS    = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int WIN_LEN      = 2 * HALF_TAPS - 1;
    localparam int CENTER       = HALF_TAPS - 1;
    localparam int NUM_COEFS    = 8;
    localparam int COEF_BITS    = 18;
    localparam int FRAC_BITS    = 17;
    localparam int CFG_IDX_BITS = $clog2(NUM_COEFS);
    localparam int TAP_BITS     = $clog2(HALF_TAPS);
    localparam int PAIR_BITS    = SAMPLE_BITS + 1;
    localparam int PROD_BITS    = COEF_BITS + PAIR_BITS;
    localparam int ACC_BITS     = PROD_BITS + TAP_BITS + 1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PAIR_BITS-1:0]   pair_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic [TAP_BITS-1:0]           tap_t;
    typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;

    localparam coef_t    COEF_CENTER_RESET = coef_t'((2 ** (COEF_BITS - 1)) - 1);
    localparam cfg_idx_t CFG_COEF_CENTER   = cfg_idx_t'(0);
    localparam tap_t     TAP_LAST          = tap_t'(HALF_TAPS - 1);
    localparam sample_t  SAMPLE_MAX        = sample_t'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam sample_t  SAMPLE_MIN        = sample_t'(-(2 ** (SAMPLE_BITS - 1)));

    typedef struct packed {
        sample_t sample;
        logic    first;
        logic    last;
    } in_word_t;

    typedef struct packed {
        sample_t filtered;
        logic    end_of_record;
    } out_word_t;

    typedef struct packed {
        logic fill;
        logic shift;
        logic load;
        logic advance;
    } win_ctrl_t;

    typedef struct packed {
        logic clear;
        logic mul;
        logic acc;
    } mac_ctrl_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHECK = 7'b0000010,
        ST_LOAD  = 7'b0000100,
        ST_MAC   = 7'b0001000,
        ST_DRAIN = 7'b0010000,
        ST_ROUND = 7'b0100000,
        ST_NEXT  = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/sfir_window.sv =====
// ----------------------------------------------------------------------------
// sfir_window
// Sample window with edge fill, and a line of mirrored pair sums that
// shifts one tap pair toward the multiplier each cycle that advance is set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfir_window (
    input  logic               clk,
    input  logic               rst_n,
    input  sfir_pkg::win_ctrl_t ctrl,
    input  sfir_pkg::sample_t   x,
    output sfir_pkg::pair_t     pair_head
);
    import sfir_pkg::*;

    sample_t win_reg [WIN_LEN];
    pair_t   pair_reg [HALF_TAPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (ctrl.fill)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_reg[i] <= x;
            end
        end
        else if (ctrl.shift)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_LEN-1] <= x;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pair_reg[0] <= pair_t'(win_reg[CENTER]);
            for (int j = 1; j < HALF_TAPS; j++)
            begin
                pair_reg[j] <= pair_t'(win_reg[CENTER-j]) + pair_t'(win_reg[CENTER+j]);
            end
        end
        else if (ctrl.advance)
        begin
            for (int j = 0; j < HALF_TAPS - 1; j++)
            begin
                pair_reg[j] <= pair_reg[j+1];
            end
        end
    end

    assign pair_head = pair_reg[0];

endmodule

`default_nettype wire

// ===== hdl/sfir_mac.sv =====
// ----------------------------------------------------------------------------
// sfir_mac
// Shared multiply-accumulate unit with round half up and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfir_mac (
    input  logic               clk,
    input  sfir_pkg::mac_ctrl_t ctrl,
    input  sfir_pkg::coef_t     coef,
    input  sfir_pkg::pair_t     operand,
    output sfir_pkg::sample_t   filtered
);
    import sfir_pkg::*;

    localparam acc_t ROUND_BIAS = acc_t'(2 ** (FRAC_BITS - 1));
    localparam acc_t SAT_HI     = acc_t'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam acc_t SAT_LO     = acc_t'(-(2 ** (SAMPLE_BITS - 1)));

    prod_t product_reg;
    acc_t  acc_reg;
    acc_t  quo;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            product_reg <= coef * operand;
        end
        if (ctrl.clear)
        begin
            acc_reg <= ROUND_BIAS;
        end
        else if (ctrl.acc)
        begin
            acc_reg <= acc_reg + acc_t'(product_reg);
        end
    end

    always_comb
    begin
        quo = acc_reg >>> FRAC_BITS;
        if (quo > SAT_HI)
        begin
            filtered = SAMPLE_MAX;
        end
        else if (quo < SAT_LO)
        begin
            filtered = SAMPLE_MIN;
        end
        else
        begin
            filtered = sample_t'(quo);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/symmetric_fir_lowpass_edge_hold.sv =====
// ----------------------------------------------------------------------------
// symmetric_fir_lowpass_edge_hold
// An input word is taken only in ST_IDLE and passes ST_CHECK; once the
// window is full, ST_LOAD, ST_MAC, ST_DRAIN and ST_ROUND make an output.
// One shared multiplier works one tap pair per cycle in ST_MAC, for all
// HALF_TAPS pairs. A last word then flushes the window in ST_NEXT steps,
// with an output for each full window. Output stalls hold the input.
// Reset clears the window to zero and loads the coefficient reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "symmetric_fir_lowpass_edge_hold_defines.svh"

module symmetric_fir_lowpass_edge_hold (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sfir_pkg::in_word_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sfir_pkg::out_word_t   out_data,
    input  logic                 cfg_we,
    input  sfir_pkg::cfg_idx_t    cfg_index,
    input  sfir_pkg::coef_t       cfg_data
);
    import sfir_pkg::*;

    state_t    state_reg, state_next;
    coef_t     coef_reg [NUM_COEFS];
    tap_t      seen_count_reg;
    tap_t      t_reg;
    tap_t      k_reg;
    tap_t      idx_reg;
    sample_t   x_reg;
    logic      last_reg;
    logic      out_valid_reg;
    out_word_t out_data_reg;

    win_ctrl_t win_ctrl;
    mac_ctrl_t mac_ctrl;
    logic      in_acc;
    logic      out_free;
    logic      out_load;
    tap_t      seen_base;
    sample_t   win_x;
    pair_t     pair_head;
    sample_t   filtered;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign seen_base = in_data.first ? '0 : seen_count_reg;
    assign win_x     = (state_reg == ST_IDLE) ? in_data.sample : x_reg;

    always_comb
    begin
        state_next = state_reg;
        win_ctrl   = '0;
        mac_ctrl   = '0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    win_ctrl.fill  = in_data.first;
                    win_ctrl.shift = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (t_reg == TAP_LAST) ? ST_LOAD : ST_NEXT;
            end
            ST_LOAD:
            begin
                win_ctrl.load  = 1'b1;
                mac_ctrl.clear = 1'b1;
                state_next     = ST_MAC;
            end
            ST_MAC:
            begin
                mac_ctrl.mul     = 1'b1;
                mac_ctrl.acc     = (idx_reg != '0);
                win_ctrl.advance = 1'b1;
                if (idx_reg == TAP_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                mac_ctrl.acc = 1'b1;
                state_next   = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (last_reg && (k_reg != TAP_LAST))
                begin
                    win_ctrl.shift = 1'b1;
                    state_next     = ST_CHECK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            seen_count_reg <= '0;
            t_reg          <= '0;
            k_reg          <= '0;
            idx_reg        <= '0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                last_reg <= in_data.last;
                t_reg    <= seen_base;
                k_reg    <= '0;
                if (in_data.last)
                begin
                    seen_count_reg <= '0;
                end
                else if (seen_base != TAP_LAST)
                begin
                    seen_count_reg <= seen_base + tap_t'(1);
                end
                else
                begin
                    seen_count_reg <= seen_base;
                end
            end
            else if (win_ctrl.shift)
            begin
                k_reg <= k_reg + tap_t'(1);
                if (t_reg != TAP_LAST)
                begin
                    t_reg <= t_reg + tap_t'(1);
                end
            end
            if (state_reg == ST_LOAD)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == ST_MAC)
            begin
                idx_reg <= idx_reg + tap_t'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg <= in_data.sample;
        end
        if (out_load)
        begin
            out_data_reg.filtered      <= filtered;
            out_data_reg.end_of_record <= last_reg && (k_reg == TAP_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                coef_reg[i] <= '0;
            end
            coef_reg[CFG_COEF_CENTER] <= COEF_CENTER_RESET;
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    sfir_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (win_ctrl),
        .x         (win_x),
        .pair_head (pair_head)
    );

    sfir_mac u_mac (
        .clk      (clk),
        .ctrl     (mac_ctrl),
        .coef     (coef_reg[cfg_idx_t'(idx_reg)]),
        .operand  (pair_head),
        .filtered (filtered)
    );

    `SFIR_ASSERT_NEXT(a_seen_clear_on_last, in_acc && in_data.last, seen_count_reg == '0, "seen count not cleared after last word")
    `SFIR_ASSERT_NEXT(a_next_idle, (state_reg == ST_NEXT) && !last_reg, state_reg == ST_IDLE, "extra work after a word without last")
    `SFIR_ASSERT_NEXT(a_round_loads_out, (state_reg == ST_ROUND) && out_free, out_valid_reg && (state_reg == ST_NEXT), "rounded result not registered")
    `SFIR_ASSERT_NEXT(a_eor_only_flush, out_load && !last_reg, !out_data_reg.end_of_record, "end of record without last")
    `SFIR_ASSERT_SAME(a_out_no_overwrite, out_load, out_free, "output word overwritten")

endmodule

`default_nettype wire

// ===== test/tb_symmetric_fir_lowpass_edge_hold.sv =====
// ----------------------------------------------------------------------------
// tb_symmetric_fir_lowpass_edge_hold
// Self-checking bench for the edge-hold symmetric FIR. A clocked driver feeds
// sample words from a queue. A clocked monitor predicts each accepted word's
// filtered outputs and checks every output word, field by field, in order.
// Coefficient sets change between phases, only while the filter is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_symmetric_fir_lowpass_edge_hold;

    import sfir_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4 * HALF_TAPS;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;
    localparam coef_t COEF_MAX   = COEF_CENTER_RESET;
    localparam coef_t COEF_MIN   = {1'b1, {(COEF_BITS - 1){1'b0}}};

    typedef enum int {
        CS_SMOOTH,
        CS_MAX,
        CS_MIN,
        CS_RANDOM,
        CS_ALTERNATE,
        CS_RESET
    } coef_set_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;
    logic      cfg_we = 1'b0;
    cfg_idx_t  cfg_index = '0;
    coef_t     cfg_data = '0;

    in_word_t  sample_q[$];
    out_word_t filtered_q[$];

    sample_t    window [WIN_LEN];
    coef_t      coefs [NUM_COEFS];
    logic [2:0] seen_run;

    int  queued_total = 0;
    int  accepted_total = 0;
    int  err_count = 0;
    int  cycle_count = 0;
    bit  in_taken = 1'b0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  rx_hold_req = 1'b0;
    bit  rx_hold_done = 1'b0;
    int  rx_hold_left = 0;

    symmetric_fir_lowpass_edge_hold uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic sample_t tap_sum();
        longint acc;
        longint q;
        int     j;
        acc = longint'(coefs[0]) * longint'(window[CENTER]);
        for (j = 1; j < HALF_TAPS; j++)
        begin
            acc += longint'(coefs[j]) *
                   (longint'(window[CENTER - j]) + longint'(window[CENTER + j]));
        end
        acc += longint'(1) << (FRAC_BITS - 1);
        q = acc >>> FRAC_BITS;
        if (q > longint'(SAMPLE_MAX))
            q = longint'(SAMPLE_MAX);
        if (q < longint'(SAMPLE_MIN))
            q = longint'(SAMPLE_MIN);
        return sample_t'(q);
    endfunction

    task automatic shift_window(sample_t x);
        int i;
        for (i = 0; i < WIN_LEN - 1; i++)
            window[i] = window[i + 1];
        window[WIN_LEN - 1] = x;
    endtask

    task automatic run_filter(in_word_t w);
        out_word_t r;
        int        t;
        int        k;
        int        i;
        if (w.first)
        begin
            for (i = 0; i < WIN_LEN; i++)
                window[i] = w.sample;
            seen_run = '0;
        end
        shift_window(w.sample);
        t = seen_run;
        if (t >= HALF_TAPS - 1)
        begin
            r.filtered      = tap_sum();
            r.end_of_record = 1'b0;
            filtered_q.push_back(r);
        end
        if (!w.last)
        begin
            if (seen_run < HALF_TAPS - 1)
                seen_run++;
        end
        else
        begin
            // flush: the final shift always yields the record's last output
            for (k = 1; k < HALF_TAPS; k++)
            begin
                shift_window(w.sample);
                t++;
                if (t >= HALF_TAPS - 1)
                begin
                    r.filtered      = tap_sum();
                    r.end_of_record = (k == HALF_TAPS - 1);
                    filtered_q.push_back(r);
                end
            end
            seen_run = '0;
        end
    endtask

    // driver: advance only once the current word is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (sample_q.size() == 0)
                in_valid <= 1'b0;
            else if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
            begin
                tx_gap = $urandom_range(1, 11) - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                in_data  <= sample_q.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // receiver: one long hold on request, otherwise random bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_req && !rx_hold_done)
            begin
                rx_hold_done = 1'b1;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct)
            begin
                rx_gap = $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_symmetric_fir_lowpass_edge_hold: errors");
            $finish;
        end
        else
        begin
            in_taken = rst_n && in_valid && in_ready;
            if (in_taken)
            begin
                run_filter(in_data);
                accepted_total++;
            end
            if (rst_n && out_valid && out_ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected output word: filtered %0d eor %0b",
                                 out_data.filtered, out_data.end_of_record);
                end
                else
                begin
                    out_word_t exp_w;
                    exp_w = filtered_q.pop_front();
                    if (out_data.filtered !== exp_w.filtered ||
                        out_data.end_of_record !== exp_w.end_of_record)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("mismatch: expected %0d eor %0b, got %0d eor %0b",
                                     exp_w.filtered, exp_w.end_of_record,
                                     out_data.filtered, out_data.end_of_record);
                    end
                end
            end
        end
    end

    task automatic push_word(sample_t s, bit f, bit l);
        in_word_t w;
        w.sample = s;
        w.first  = f;
        w.last   = l;
        sample_q.push_back(w);
        queued_total++;
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return sample_t'(int'($urandom_range(0, 200)) - 100);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic add_record(int len, bit with_first, bit with_last);
        int i;
        for (i = 0; i < len; i++)
            push_word(pick_sample(), with_first && i == 0, with_last && i == len - 1);
    endtask

    task automatic wait_drained();
        while (accepted_total != queued_total || filtered_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_coefs(coef_set_t cs);
        int    k;
        coef_t v;
        for (k = 0; k < NUM_COEFS; k++)
        begin
            case (cs)
                CS_SMOOTH:
                    case (k)
                        0: v = coef_t'(30000);
                        1: v = coef_t'(22000);
                        2: v = coef_t'(12000);
                        3: v = coef_t'(5000);
                        4: v = coef_t'(1500);
                        5: v = coef_t'(-800);
                        6: v = coef_t'(-600);
                        default: v = coef_t'(-200);
                    endcase
                CS_MAX:       v = COEF_MAX;
                CS_MIN:       v = COEF_MIN;
                CS_RANDOM:    v = coef_t'($urandom);
                CS_ALTERNATE: v = (k % 2 == 0) ? COEF_MAX : COEF_MIN;
                default:      v = (k == 0) ? COEF_CENTER_RESET : coef_t'(0);
            endcase
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_COEF_CENTER + cfg_idx_t'(k);
            cfg_data  <= v;
            coefs[k]  = v;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(coef_set_t cs, int n_items, int tx_pct, int rx_pct, bit hold);
        int count;
        int len;
        load_coefs(cs);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (hold)
            rx_hold_req = 1'b1;
        count = 0;
        while (count < n_items)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    len = $urandom_range(1, 3);
                    add_record(len, 1'b0, 1'b0);
                end
                1:
                begin
                    len = $urandom_range(1, 12);
                    add_record(len, 1'b1, 1'b0);
                end
                2:
                begin
                    len = 1;
                    add_record(len, 1'b1, 1'b1);
                end
                default:
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                                      : $urandom_range(2, 16);
                    add_record(len, 1'b1, 1'b1);
                end
            endcase
            count += len;
        end
        wait_drained();
    endtask

    initial
    begin
        int i;
        for (i = 0; i < WIN_LEN; i++)
            window[i] = '0;
        for (i = 0; i < NUM_COEFS; i++)
            coefs[i] = (i == 0) ? COEF_CENTER_RESET : coef_t'(0);
        seen_run = '0;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        load_coefs(CS_SMOOTH);
        tx_idle_pct = 15;
        rx_idle_pct = 15;
        // words with no first, straight after reset
        push_word(sample_t'(1000), 1'b0, 1'b0);
        push_word(sample_t'(-2000), 1'b0, 1'b0);
        push_word(sample_t'(3000), 1'b0, 1'b0);
        push_word(sample_t'(500), 1'b0, 1'b1);
        // single-word records at both extremes
        push_word(SAMPLE_MAX, 1'b1, 1'b1);
        push_word(SAMPLE_MIN, 1'b1, 1'b1);
        // record left open, then dropped by the next first
        push_word(SAMPLE_MAX, 1'b1, 1'b0);
        for (i = 0; i < 8; i++)
            push_word((i % 2 == 0) ? SAMPLE_MIN : SAMPLE_MAX, 1'b0, 1'b0);
        push_word(sample_t'(-7), 1'b1, 1'b0);
        push_word(SAMPLE_MIN, 1'b0, 1'b0);
        push_word(SAMPLE_MAX, 1'b0, 1'b1);
        // continue on the held tail of the previous record
        push_word(sample_t'(100), 1'b0, 1'b0);
        push_word(sample_t'(-100), 1'b0, 1'b1);
        wait_drained();

        run_phase(CS_MAX, 22, 20, 20, 1'b0);
        run_phase(CS_MIN, 22, 0, 10, 1'b1);
        run_phase(CS_RANDOM, 22, 0, 40, 1'b0);
        run_phase(CS_ALTERNATE, 22, 30, 0, 1'b0);
        run_phase(CS_RANDOM, 22, 10, 10, 1'b0);
        run_phase(CS_RESET, 22, 0, 0, 1'b0);

        if (err_count == 0)
            $display("tb_symmetric_fir_lowpass_edge_hold: clean");
        else
            $display("tb_symmetric_fir_lowpass_edge_hold: errors");
        $finish;
    end

endmodule
